>>> rtl/core/lpx_pkg.sv
// Shared types and constants of the link packet exchange block.
// No dependencies; every other file of the block but lpx_ifs refers to it by scoped names.
`default_nettype none

package lpx_pkg;

    // Default send buffer depth in bytes
    localparam int BUFFER_DEPTH = 256;

    // Default depth of the result queue, in result items (at least 2)
    localparam int RESULT_DEPTH = 4;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_TRIES = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TX_HS     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RX_HS     = 2'd2;

    // Register reset values
    localparam logic [7:0] MAX_TRIES_RST = 8'd20;
    localparam logic [7:0] TX_HS_RST     = 8'hAA;
    localparam logic [7:0] RX_HS_RST     = 8'h55;

    // Byte clocked out to read one reply byte
    localparam logic [7:0] FILL_BYTE = 8'h00;

    // Input command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_REPLY = 1'b1;

    // Result destination codes
    typedef enum logic [1:0] {
        DEST_LINK = 2'd0,
        DEST_HOST = 2'd1,
        DEST_FAIL = 2'd2
    } dest_t;

    // One result item
    typedef struct packed {
        dest_t      destination;
        logic [7:0] out_byte;
        logic       host_last;
    } result_t;

    // Results produced by one accepted item (count is 0, 1 or 2)
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

`default_nettype wire

>>> rtl/core/lpx_ifs.sv
// Valid/ready channel interfaces of the link packet exchange block:
// the command item channel and the result item channel. No dependencies.
`default_nettype none

interface lpx_cmd_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] data_byte;
    logic       last_load;

    modport source (output valid, output command, output data_byte, output last_load,
                    input ready);
    modport sink   (input valid, input command, input data_byte, input last_load,
                    output ready);
endinterface

interface lpx_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] destination;
    logic [7:0] out_byte;
    logic       host_last;

    modport source (output valid, output destination, output out_byte, output host_last,
                    input ready);
    modport sink   (input valid, input destination, input out_byte, input host_last,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/core/lpx_result_fifo.sv
// Result queue: takes up to two result items a cycle, hands out one.
// Depends on lpx_pkg (result_t, push_t).
`default_nettype none

module lpx_result_fifo #(
    parameter int DEPTH = lpx_pkg::RESULT_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire lpx_pkg::push_t   push,
    input  wire logic             pop,
    output lpx_pkg::result_t      head,
    output logic                  head_valid,
    output logic                  space2
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    lpx_pkg::result_t entry_reg [DEPTH];

    logic [AW-1:0] wr_ptr_reg, wr_ptr_next, wr_ptr_plus1;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    // Pointer arithmetic with wrap at any depth
    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        if (p == AW'(DEPTH - 1))
            r = '0;
        else
            r = p + AW'(1);
        return r;
    endfunction

    always_comb
    begin
        wr_ptr_plus1 = ptr_inc(wr_ptr_reg);
        case (push.count)
            2'd1:    wr_ptr_next = wr_ptr_plus1;
            2'd2:    wr_ptr_next = ptr_inc(wr_ptr_plus1);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CW'(push.count) - CW'(pop);
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            entry_reg[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            entry_reg[wr_ptr_plus1] <= push.second;
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head       = entry_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign space2     = (count_reg <= CW'(DEPTH - 2));

    // Never pushed past capacity, never popped while empty
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |-> (CW'(push.count) <= CW'(DEPTH) - count_reg + CW'(pop)))
        else $error("result queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("result queue popped while empty");
    a_level_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count == 2'd0 && !pop) |=> $stable(count_reg))
        else $error("result queue level moved without push or pop");

endmodule

`default_nettype wire

>>> rtl/core/link_packet_exchange_top.sv
// Link packet exchange, master side.
// cmd_ch carries command items: a host load byte (command 0, with last_load on the
// final byte of the packet) or a byte that the partner returned (command 1).
// res_ch carries result items: a byte to put on the link, a byte for the host
// (host_last on the final one), or a failure notice.
// The cfg_* port writes max_tries, tx_handshake and rx_handshake; write it only
// while no exchange is in flight.
// Each command item is handled in the cycle it is accepted; its zero, one or two
// results are registered into a result queue, whose head drives res_ch.
// cmd_ch.ready is high while the queue has room for two results, so items are taken
// one a cycle as long as res_ch drains; a reply that yields two results holds the
// pace to the one result a cycle that res_ch moves.
// The send buffer is a memory with one write port at the fill count and one read
// port read ahead at the next byte index, so a data byte is queued in the cycle
// its reply is accepted.
// Reset clears the phase, the counters and the result queue and restores the
// register defaults; no clearing pass runs. A stalled res_ch fills the queue and
// then drops cmd_ch.ready until space returns.
// Depends on lpx_pkg, lpx_ifs (lpx_cmd_if, lpx_res_if) and lpx_result_fifo.
`default_nettype none

module link_packet_exchange_top #(
    parameter int BUFFER_DEPTH = lpx_pkg::BUFFER_DEPTH,
    parameter int RESULT_DEPTH = lpx_pkg::RESULT_DEPTH
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    lpx_cmd_if.sink                            cmd_ch,
    lpx_res_if.source                          res_ch,
    input  wire logic                          cfg_we,
    input  wire logic [lpx_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [7:0]                    cfg_data
);

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CW = $clog2(BUFFER_DEPTH + 1);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_TX_HS,
        PH_TX_DATA,
        PH_RX_HS,
        PH_RX_LEN,
        PH_RX_DATA
    } phase_t;

    // Configuration registers
    logic [7:0] max_tries_reg, tx_hs_reg, rx_hs_reg;

    // Exchange state
    phase_t        phase_reg, phase_next;
    logic [7:0]    try_count_reg, try_count_next;
    logic [CW-1:0] send_count_reg, send_count_next;
    logic [CW-1:0] byte_index_reg, byte_index_next;
    logic [7:0]    rx_left_reg, rx_left_next;

    // Send buffer and its read-ahead data
    logic [7:0]    buf_mem [BUFFER_DEPTH];
    logic [7:0]    rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] wr_addr, rd_addr;

    logic             accept;
    logic [7:0]       try_inc;
    logic [CW-1:0]    len_m1;
    lpx_pkg::push_t   push;
    lpx_pkg::result_t head;
    logic             head_valid, space2, pop;

    // Result item builder
    function automatic lpx_pkg::result_t mk_result(input lpx_pkg::dest_t dest,
                                                   input logic [7:0] b,
                                                   input logic last);
        lpx_pkg::result_t r;
        r.destination = dest;
        r.out_byte    = b;
        r.host_last   = last;
        return r;
    endfunction

    assign accept  = cmd_ch.valid && cmd_ch.ready;
    assign try_inc = try_count_reg + 8'd1;
    assign len_m1  = send_count_reg - CW'(1);
    assign wr_addr = send_count_reg[AW-1:0];
    assign rd_addr = byte_index_next[AW-1:0];

    // Item handling
    always_comb
    begin
        phase_next      = phase_reg;
        try_count_next  = try_count_reg;
        send_count_next = send_count_reg;
        byte_index_next = byte_index_reg;
        rx_left_next    = rx_left_reg;
        mem_we          = 1'b0;
        push.count      = 2'd0;
        push.first      = mk_result(lpx_pkg::DEST_LINK, lpx_pkg::FILL_BYTE, 1'b0);
        push.second     = mk_result(lpx_pkg::DEST_LINK, lpx_pkg::FILL_BYTE, 1'b0);

        if (accept)
        begin
            if (cmd_ch.command == lpx_pkg::CMD_LOAD)
            begin
                // Loads count only between exchanges; a full buffer drops bytes
                if (phase_reg == PH_IDLE)
                begin
                    if (send_count_reg < CW'(BUFFER_DEPTH))
                    begin
                        mem_we          = 1'b1;
                        send_count_next = send_count_reg + CW'(1);
                    end
                    if (cmd_ch.last_load)
                    begin
                        phase_next     = PH_TX_HS;
                        try_count_next = '0;
                        push.count     = 2'd1;
                        push.first     = mk_result(lpx_pkg::DEST_LINK, tx_hs_reg, 1'b0);
                    end
                end
            end
            else
            begin
                case (phase_reg)
                    PH_TX_HS:
                    begin
                        push.count = 2'd1;
                        if (cmd_ch.data_byte == tx_hs_reg)
                        begin
                            phase_next      = PH_TX_DATA;
                            byte_index_next = '0;
                            push.first      = mk_result(lpx_pkg::DEST_LINK, 8'(len_m1), 1'b0);
                        end
                        else if (try_inc >= max_tries_reg)
                        begin
                            phase_next      = PH_IDLE;
                            send_count_next = '0;
                            byte_index_next = '0;
                            try_count_next  = '0;
                            push.first      = mk_result(lpx_pkg::DEST_FAIL, 8'h00, 1'b0);
                        end
                        else
                        begin
                            try_count_next = try_inc;
                            push.first     = mk_result(lpx_pkg::DEST_LINK, tx_hs_reg, 1'b0);
                        end
                    end
                    PH_TX_DATA:
                    begin
                        push.count = 2'd1;
                        if (byte_index_reg < send_count_reg)
                        begin
                            byte_index_next = byte_index_reg + CW'(1);
                            push.first      = mk_result(lpx_pkg::DEST_LINK, rd_data_reg, 1'b0);
                        end
                        else
                        begin
                            phase_next     = PH_RX_HS;
                            try_count_next = '0;
                            push.first     = mk_result(lpx_pkg::DEST_LINK, rx_hs_reg, 1'b0);
                        end
                    end
                    PH_RX_HS:
                    begin
                        push.count = 2'd1;
                        if (cmd_ch.data_byte == rx_hs_reg)
                        begin
                            phase_next = PH_RX_LEN;
                            push.first = mk_result(lpx_pkg::DEST_LINK, rx_hs_reg, 1'b0);
                        end
                        else if (try_inc >= max_tries_reg)
                        begin
                            phase_next      = PH_IDLE;
                            send_count_next = '0;
                            byte_index_next = '0;
                            try_count_next  = '0;
                            push.first      = mk_result(lpx_pkg::DEST_FAIL, 8'h00, 1'b0);
                        end
                        else
                        begin
                            try_count_next = try_inc;
                            push.first     = mk_result(lpx_pkg::DEST_LINK, rx_hs_reg, 1'b0);
                        end
                    end
                    PH_RX_LEN:
                    begin
                        // Reply is the length minus one: one more than that many bytes follow it
                        rx_left_next    = cmd_ch.data_byte;
                        byte_index_next = '0;
                        phase_next      = PH_RX_DATA;
                        push.count      = 2'd2;
                        push.first      = mk_result(lpx_pkg::DEST_HOST, cmd_ch.data_byte, 1'b0);
                        push.second     = mk_result(lpx_pkg::DEST_LINK, lpx_pkg::FILL_BYTE,
                                                    1'b0);
                    end
                    PH_RX_DATA:
                    begin
                        if (rx_left_reg == 8'd0)
                        begin
                            phase_next      = PH_IDLE;
                            send_count_next = '0;
                            byte_index_next = '0;
                            try_count_next  = '0;
                            push.count      = 2'd1;
                            push.first      = mk_result(lpx_pkg::DEST_HOST, cmd_ch.data_byte,
                                                        1'b1);
                        end
                        else
                        begin
                            rx_left_next = rx_left_reg - 8'd1;
                            push.count   = 2'd2;
                            push.first   = mk_result(lpx_pkg::DEST_HOST, cmd_ch.data_byte,
                                                     1'b0);
                            push.second  = mk_result(lpx_pkg::DEST_LINK, lpx_pkg::FILL_BYTE,
                                                     1'b0);
                        end
                    end
                    PH_IDLE:
                    begin
                        // Replies between exchanges are dropped
                    end
                    default:
                    begin
                        phase_next      = PH_IDLE;
                        send_count_next = '0;
                        byte_index_next = '0;
                        try_count_next  = '0;
                    end
                endcase
            end
        end
    end

    // Send buffer: write at the fill count, read ahead at the next byte index
    always_ff @(posedge clk)
    begin
        if (mem_we)
            buf_mem[wr_addr] <= cmd_ch.data_byte;
        if (mem_we && (wr_addr == rd_addr))
            rd_data_reg <= cmd_ch.data_byte;
        else
            rd_data_reg <= buf_mem[rd_addr];
    end

    // Phase and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            try_count_reg  <= '0;
            send_count_reg <= '0;
            byte_index_reg <= '0;
            rx_left_reg    <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            try_count_reg  <= try_count_next;
            send_count_reg <= send_count_next;
            byte_index_reg <= byte_index_next;
            rx_left_reg    <= rx_left_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_tries_reg <= lpx_pkg::MAX_TRIES_RST;
            tx_hs_reg     <= lpx_pkg::TX_HS_RST;
            rx_hs_reg     <= lpx_pkg::RX_HS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lpx_pkg::CFG_MAX_TRIES: max_tries_reg <= cfg_data;
                lpx_pkg::CFG_TX_HS:     tx_hs_reg     <= cfg_data;
                lpx_pkg::CFG_RX_HS:     rx_hs_reg     <= cfg_data;
                default:
                begin
                    // Unmapped index: no register
                end
            endcase
        end
    end

    // Result queue
    lpx_result_fifo #(
        .DEPTH (RESULT_DEPTH)
    ) u_result_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .space2     (space2)
    );

    assign cmd_ch.ready       = space2;
    assign res_ch.valid       = head_valid;
    assign res_ch.destination = head.destination;
    assign res_ch.out_byte    = head.out_byte;
    assign res_ch.host_last   = head.host_last;
    assign pop                = res_ch.valid && res_ch.ready;

    // Read-ahead address must sit at entry zero between exchanges
    a_idle_index: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (byte_index_reg == '0))
        else $error("byte index not cleared in idle");
    // An exchange always has at least one byte to send
    a_busy_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_IDLE) |-> (send_count_reg != '0))
        else $error("exchange running with empty send buffer");
    a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_TX_DATA) |-> (byte_index_reg <= send_count_reg &&
                                       send_count_reg <= CW'(BUFFER_DEPTH)))
        else $error("send index beyond fill count");
    // A load during an exchange changes nothing and gives no result
    a_busy_load: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd_ch.command == lpx_pkg::CMD_LOAD && phase_reg != PH_IDLE)
        |-> (push.count == 2'd0 && !mem_we))
        else $error("load taken during an exchange");

endmodule

`default_nettype wire

>>> tb/sv/tb_link_packet_exchange_top.sv
// Self-checking testbench for link_packet_exchange_top: a directed table, then random
// exchanges under several register settings, checked against a built-in protocol predictor.
// Depends on lpx_pkg, lpx_ifs (lpx_cmd_if, lpx_res_if) and the RTL of the block.

module tb_link_packet_exchange_top;

    localparam int HALF_PERIOD       = 4;
    localparam int RESET_CYCLES      = 7;
    localparam int STALL_LIMIT       = 2000;  // cycles with no item moving on either channel
    localparam int SETTLE_CYCLES     = 6;     // block latency plus margin
    localparam int ITEMS_PER_SETTING = 165;
    localparam int NUM_SETTINGS      = 6;

    // Exchange progress as tracked by the predictor
    typedef enum logic [2:0] {
        LS_IDLE,
        LS_TX_HS,
        LS_TX_DATA,
        LS_RX_HS,
        LS_RX_LEN,
        LS_RX_DATA
    } link_state_t;

    // Receiver back-pressure styles
    typedef enum int {
        STALL_NONE,
        STALL_COIN,
        STALL_QUARTER,
        STALL_LONG
    } stall_mode_t;

    // One row of the directed table
    typedef struct {
        logic             cmd;
        logic [7:0]       dat;
        logic             lst;
        bit               typed;
        lpx_pkg::result_t res;
    } stim_row_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [lpx_pkg::CFG_INDEX_W-1:0] cfg_index = lpx_pkg::CFG_MAX_TRIES;
    logic [7:0]                      cfg_data = 8'h00;

    lpx_cmd_if cmd_ch();
    lpx_res_if res_ch();

    link_packet_exchange_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_ch    (cmd_ch),
        .res_ch    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    // Predictor state and register shadows
    link_state_t lk_state;
    logic [7:0]  lk_tries;
    logic [7:0]  lk_buf [lpx_pkg::BUFFER_DEPTH];
    logic [8:0]  lk_sent;
    logic [8:0]  lk_index;
    logic [8:0]  lk_rx_len;
    logic [7:0]  r_max_tries;
    logic [7:0]  r_tx_hs;
    logic [7:0]  r_rx_hs;

    lpx_pkg::result_t pending_results[$];
    stim_row_t        directed_rows[$];
    int               errors = 0;
    int               useful_items = 0;
    int unsigned      idle_cycles = 0;
    bit               row_typed = 1'b0;
    lpx_pkg::result_t row_res;
    int               burst_left = 0;
    int               load_left = 0;
    bit               stubborn = 1'b0;

    function automatic lpx_pkg::result_t mk_res(lpx_pkg::dest_t d, logic [7:0] b, logic hl);
        lpx_pkg::result_t r;
        r.destination = d;
        r.out_byte    = b;
        r.host_last   = hl;
        return r;
    endfunction

    function automatic void link_go_idle();
        lk_state = LS_IDLE;
        lk_sent  = '0;
        lk_index = '0;
        lk_tries = '0;
    endfunction

    // Handshake not echoed: resend it, or give up once the tries run out
    function automatic lpx_pkg::result_t handshake_retry(logic [7:0] hs);
        lk_tries = lk_tries + 8'd1;
        if (lk_tries >= r_max_tries)
        begin
            link_go_idle();
            return mk_res(lpx_pkg::DEST_FAIL, 8'h00, 1'b0);
        end
        return mk_res(lpx_pkg::DEST_LINK, hs, 1'b0);
    endfunction

    // Results caused by one accepted command item
    task automatic exchange_predict(input logic cmd, input logic [7:0] dat, input logic lst,
                                    output int n, output lpx_pkg::result_t r0,
                                    output lpx_pkg::result_t r1, output bit ignored);
        logic [8:0] len_m1;
        n = 0;
        ignored = 1'b0;
        r0 = '0;
        r1 = '0;
        if (cmd == lpx_pkg::CMD_LOAD)
        begin
            if (lk_state != LS_IDLE)
                ignored = 1'b1;
            else
            begin
                // bytes past the buffer end are dropped
                if (lk_sent < lpx_pkg::BUFFER_DEPTH)
                begin
                    lk_buf[lk_sent[7:0]] = dat;
                    lk_sent = lk_sent + 9'd1;
                end
                if (lst)
                begin
                    lk_state = LS_TX_HS;
                    lk_tries = '0;
                    r0 = mk_res(lpx_pkg::DEST_LINK, r_tx_hs, 1'b0);
                    n = 1;
                end
            end
        end
        else
        begin
            case (lk_state)
                LS_IDLE: ignored = 1'b1;
                LS_TX_HS:
                begin
                    n = 1;
                    if (dat == r_tx_hs)
                    begin
                        lk_state = LS_TX_DATA;
                        lk_index = '0;
                        len_m1 = lk_sent - 9'd1;
                        r0 = mk_res(lpx_pkg::DEST_LINK, len_m1[7:0], 1'b0);
                    end
                    else
                        r0 = handshake_retry(r_tx_hs);
                end
                LS_TX_DATA:
                begin
                    n = 1;
                    if (lk_index < lk_sent)
                    begin
                        r0 = mk_res(lpx_pkg::DEST_LINK, lk_buf[lk_index[7:0]], 1'b0);
                        lk_index = lk_index + 9'd1;
                    end
                    else
                    begin
                        lk_state = LS_RX_HS;
                        lk_tries = '0;
                        r0 = mk_res(lpx_pkg::DEST_LINK, r_rx_hs, 1'b0);
                    end
                end
                LS_RX_HS:
                begin
                    n = 1;
                    if (dat == r_rx_hs)
                    begin
                        lk_state = LS_RX_LEN;
                        r0 = mk_res(lpx_pkg::DEST_LINK, r_rx_hs, 1'b0);
                    end
                    else
                        r0 = handshake_retry(r_rx_hs);
                end
                LS_RX_LEN:
                begin
                    lk_rx_len = {1'b0, dat} + 9'd1;
                    lk_index = '0;
                    lk_state = LS_RX_DATA;
                    r0 = mk_res(lpx_pkg::DEST_HOST, dat, 1'b0);
                    r1 = mk_res(lpx_pkg::DEST_LINK, lpx_pkg::FILL_BYTE, 1'b0);
                    n = 2;
                end
                LS_RX_DATA:
                begin
                    lk_index = lk_index + 9'd1;
                    if (lk_index >= lk_rx_len)
                    begin
                        r0 = mk_res(lpx_pkg::DEST_HOST, dat, 1'b1);
                        link_go_idle();
                        n = 1;
                    end
                    else
                    begin
                        r0 = mk_res(lpx_pkg::DEST_HOST, dat, 1'b0);
                        r1 = mk_res(lpx_pkg::DEST_LINK, lpx_pkg::FILL_BYTE, 1'b0);
                        n = 2;
                    end
                end
                default: link_go_idle();
            endcase
        end
    endtask

    // Sample both channels at the rising edge: predict on commands, check results
    always @(posedge clk)
    begin : chan_monitor
        int               n;
        lpx_pkg::result_t r0;
        lpx_pkg::result_t r1;
        lpx_pkg::result_t want;
        bit               ign;
        bit               moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                moved = 1'b1;
                exchange_predict(cmd_ch.command, cmd_ch.data_byte, cmd_ch.last_load,
                                 n, r0, r1, ign);
                if (!ign)
                    useful_items++;
                if (row_typed)
                    pending_results.push_back(row_res);
                else
                begin
                    if (n > 0)
                        pending_results.push_back(r0);
                    if (n > 1)
                        pending_results.push_back(r1);
                end
            end
            if (res_ch.valid && res_ch.ready)
            begin
                moved = 1'b1;
                if (pending_results.size() == 0)
                begin
                    errors++;
                    $display({"%0t: result expected none got destination %0d byte 0x%02h",
                              " last %0d"},
                             $time, res_ch.destination, res_ch.out_byte, res_ch.host_last);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (res_ch.destination !== want.destination)
                    begin
                        errors++;
                        $display("%0t: destination expected %0d got %0d",
                                 $time, want.destination, res_ch.destination);
                    end
                    if (res_ch.out_byte !== want.out_byte)
                    begin
                        errors++;
                        $display("%0t: out_byte expected 0x%02h got 0x%02h",
                                 $time, want.out_byte, res_ch.out_byte);
                    end
                    if (res_ch.host_last !== want.host_last)
                    begin
                        errors++;
                        $display("%0t: host_last expected %0d got %0d",
                                 $time, want.host_last, res_ch.host_last);
                    end
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
        end
    end

    // Watchdog: nothing moving for too long ends the run
    initial
    begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("tb_link_packet_exchange_top: FAIL");
        $finish;
    end

    // Result receiver back-pressure, in styles picked at random one after another
    initial
    begin : res_stall
        stall_mode_t mode;
        int          hold;
        int          tick;
        res_ch.ready = 1'b0;
        hold = 0;
        tick = 0;
        forever
        begin
            mode = stall_mode_t'($urandom_range(0, 3));
            repeat ($urandom_range(50, 300))
            begin
                @(negedge clk);
                tick++;
                case (mode)
                    STALL_NONE:    res_ch.ready = 1'b1;
                    STALL_COIN:    res_ch.ready = 1'($urandom_range(0, 1));
                    STALL_QUARTER: res_ch.ready = (tick % 4 == 0);
                    default:
                    begin
                        if (hold == 0)
                        begin
                            res_ch.ready = ~res_ch.ready;
                            hold = res_ch.ready ? $urandom_range(1, 8) : $urandom_range(1, 25);
                        end
                        else
                            hold--;
                    end
                endcase
            end
        end
    end

    // Offer one command item at a falling edge and hold it until taken; bursts and gaps
    task automatic send_item(input logic c, input logic [7:0] d, input logic l,
                             input bit typed, input lpx_pkg::result_t res);
        cmd_ch.command   = c;
        cmd_ch.data_byte = d;
        cmd_ch.last_load = l;
        row_typed        = typed;
        row_res          = res;
        cmd_ch.valid     = 1'b1;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        @(negedge clk);
        row_typed = 1'b0;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            cmd_ch.valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(0, 20);
        end
    endtask

    // Stop sending until every expected result has come back
    task automatic hold_for_results();
        cmd_ch.valid = 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [lpx_pkg::CFG_INDEX_W-1:0] idx, input logic [7:0] v);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = v;
        case (idx)
            lpx_pkg::CFG_MAX_TRIES: r_max_tries = v;
            lpx_pkg::CFG_TX_HS:     r_tx_hs = v;
            lpx_pkg::CFG_RX_HS:     r_rx_hs = v;
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic add_row(input logic c, input logic [7:0] d, input logic l, input bit typed,
                           input lpx_pkg::dest_t dest, input logic [7:0] b, input logic hl);
        stim_row_t row;
        row.cmd   = c;
        row.dat   = d;
        row.lst   = l;
        row.typed = typed;
        row.res   = mk_res(dest, b, hl);
        directed_rows.push_back(row);
    endtask

    // Next random item, shaped by where the exchange stands; wind-down plays it straight
    task automatic pick_item(input bit wind, output logic c, output logic [7:0] d,
                             output logic l);
        logic [7:0] hs;
        logic [7:0] flip;
        int         roll;
        c = lpx_pkg::CMD_REPLY;
        d = 8'($urandom_range(0, 255));
        l = 1'($urandom_range(0, 1));
        // stray item of any kind
        if (!wind && $urandom_range(0, 99) < 4)
            return;
        l = 1'b0;
        case (lk_state)
            LS_IDLE:
            begin
                // partner byte with no exchange running
                if ($urandom_range(0, 99) < 5)
                    return;
                if (load_left == 0)
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 88)
                        load_left = $urandom_range(1, 8);
                    else if (roll < 97)
                        load_left = $urandom_range(9, 64);
                    else
                        load_left = $urandom_range(250, 300);
                    stubborn = ($urandom_range(0, 15) == 0);
                end
                c = lpx_pkg::CMD_LOAD;
                l = (load_left == 1);
                load_left--;
            end
            LS_TX_HS, LS_RX_HS:
            begin
                hs = (lk_state == LS_TX_HS) ? r_tx_hs : r_rx_hs;
                flip = 8'($urandom_range(1, 255));
                if (!wind && (stubborn || $urandom_range(0, 9) < 3))
                    d = hs ^ flip;
                else
                    d = hs;
            end
            LS_RX_LEN:
            begin
                roll = $urandom_range(0, 99);
                if (wind || roll < 85)
                    d = 8'($urandom_range(0, 7));
                else if (roll < 95)
                    d = 8'($urandom_range(8, 40));
                else
                    d = 8'($urandom_range(200, 255));
            end
            default:
            begin
                // load attempt in the middle of an exchange
                if (!wind && $urandom_range(0, 99) < 3)
                begin
                    c = lpx_pkg::CMD_LOAD;
                    l = 1'($urandom_range(0, 1));
                end
            end
        endcase
    endtask

    initial
    begin : stimulus
        logic c;
        logic [7:0] d;
        logic l;
        int   start;
        bit   paused;
        cmd_ch.valid     = 1'b0;
        cmd_ch.command   = lpx_pkg::CMD_LOAD;
        cmd_ch.data_byte = 8'h00;
        cmd_ch.last_load = 1'b0;
        r_max_tries = lpx_pkg::MAX_TRIES_RST;
        r_tx_hs     = lpx_pkg::TX_HS_RST;
        r_rx_hs     = lpx_pkg::RX_HS_RST;
        lk_rx_len   = '0;
        link_go_idle();

        // Directed table under the reset settings
        add_row(lpx_pkg::CMD_REPLY, 8'hAA, 1'b0, 1'b0, lpx_pkg::DEST_LINK, 8'h00,
                1'b0);  // reply while idle
        add_row(lpx_pkg::CMD_LOAD, 8'h00, 1'b0, 1'b0, lpx_pkg::DEST_LINK, 8'h00, 1'b0);
        add_row(lpx_pkg::CMD_LOAD, 8'hFF, 1'b0, 1'b0, lpx_pkg::DEST_LINK, 8'h00, 1'b0);
        add_row(lpx_pkg::CMD_LOAD, 8'h5A, 1'b1, 1'b1, lpx_pkg::DEST_LINK, lpx_pkg::TX_HS_RST,
                1'b0);
        add_row(lpx_pkg::CMD_LOAD, 8'h11, 1'b1, 1'b0, lpx_pkg::DEST_LINK, 8'h00,
                1'b0);  // load mid-exchange
        add_row(lpx_pkg::CMD_REPLY, 8'h00, 1'b0, 1'b1, lpx_pkg::DEST_LINK, lpx_pkg::TX_HS_RST,
                1'b0);  // no echo: retry
        add_row(lpx_pkg::CMD_REPLY, lpx_pkg::TX_HS_RST, 1'b0, 1'b1, lpx_pkg::DEST_LINK, 8'h02,
                1'b0);
        add_row(lpx_pkg::CMD_REPLY, 8'hFF, 1'b0, 1'b0, lpx_pkg::DEST_LINK, 8'h00, 1'b0);
        add_row(lpx_pkg::CMD_REPLY, 8'h00, 1'b0, 1'b0, lpx_pkg::DEST_LINK, 8'h00, 1'b0);
        add_row(lpx_pkg::CMD_REPLY, 8'h12, 1'b0, 1'b0, lpx_pkg::DEST_LINK, 8'h00, 1'b0);
        add_row(lpx_pkg::CMD_REPLY, 8'h34, 1'b0, 1'b1, lpx_pkg::DEST_LINK, lpx_pkg::RX_HS_RST,
                1'b0);
        add_row(lpx_pkg::CMD_REPLY, 8'hFF, 1'b0, 1'b1, lpx_pkg::DEST_LINK, lpx_pkg::RX_HS_RST,
                1'b0);
        add_row(lpx_pkg::CMD_REPLY, lpx_pkg::RX_HS_RST, 1'b0, 1'b1, lpx_pkg::DEST_LINK,
                lpx_pkg::RX_HS_RST, 1'b0);
        add_row(lpx_pkg::CMD_REPLY, 8'h01, 1'b0, 1'b0, lpx_pkg::DEST_LINK, 8'h00,
                1'b0);  // length byte
        add_row(lpx_pkg::CMD_REPLY, 8'hFF, 1'b0, 1'b0, lpx_pkg::DEST_LINK, 8'h00, 1'b0);
        add_row(lpx_pkg::CMD_REPLY, 8'h80, 1'b0, 1'b1, lpx_pkg::DEST_HOST, 8'h80, 1'b1);
        add_row(lpx_pkg::CMD_REPLY, 8'h33, 1'b0, 1'b0, lpx_pkg::DEST_LINK, 8'h00, 1'b0);
        add_row(lpx_pkg::CMD_LOAD, 8'hC3, 1'b1, 1'b1, lpx_pkg::DEST_LINK, lpx_pkg::TX_HS_RST,
                1'b0);  // one-byte packet
        add_row(lpx_pkg::CMD_REPLY, lpx_pkg::TX_HS_RST, 1'b0, 1'b1, lpx_pkg::DEST_LINK, 8'h00,
                1'b0);
        add_row(lpx_pkg::CMD_REPLY, 8'hAA, 1'b0, 1'b0, lpx_pkg::DEST_LINK, 8'h00, 1'b0);
        add_row(lpx_pkg::CMD_REPLY, 8'h00, 1'b0, 1'b0, lpx_pkg::DEST_LINK, 8'h00, 1'b0);
        add_row(lpx_pkg::CMD_REPLY, lpx_pkg::RX_HS_RST, 1'b0, 1'b0, lpx_pkg::DEST_LINK, 8'h00,
                1'b0);
        add_row(lpx_pkg::CMD_REPLY, 8'h00, 1'b0, 1'b0, lpx_pkg::DEST_LINK, 8'h00,
                1'b0);  // one reply byte
        add_row(lpx_pkg::CMD_REPLY, 8'h7E, 1'b0, 1'b1, lpx_pkg::DEST_HOST, 8'h7E, 1'b1);

        // Reset
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].cmd, directed_rows[i].dat, directed_rows[i].lst,
                      directed_rows[i].typed, directed_rows[i].res);

        // Random exchanges, one register setting at a time
        for (int p = 0; p < NUM_SETTINGS; p++)
        begin
            hold_for_results();
            repeat (SETTLE_CYCLES) @(negedge clk);
            case (p)
                0:
                begin
                    write_reg(lpx_pkg::CFG_MAX_TRIES, 8'd1);
                    write_reg(lpx_pkg::CFG_TX_HS, 8'h00);
                    write_reg(lpx_pkg::CFG_RX_HS, 8'hFF);
                end
                1:
                begin
                    // zero tries acts as one
                    write_reg(lpx_pkg::CFG_MAX_TRIES, 8'd0);
                    write_reg(lpx_pkg::CFG_TX_HS, 8'hFF);
                    write_reg(lpx_pkg::CFG_RX_HS, 8'h00);
                end
                2:
                begin
                    write_reg(lpx_pkg::CFG_MAX_TRIES, 8'd255);
                    write_reg(lpx_pkg::CFG_TX_HS, 8'($urandom_range(0, 255)));
                    write_reg(lpx_pkg::CFG_RX_HS, 8'($urandom_range(0, 255)));
                end
                3:
                begin
                    // same byte for both handshakes
                    d = 8'($urandom_range(0, 255));
                    write_reg(lpx_pkg::CFG_MAX_TRIES, 8'($urandom_range(2, 6)));
                    write_reg(lpx_pkg::CFG_TX_HS, d);
                    write_reg(lpx_pkg::CFG_RX_HS, d);
                end
                4:
                begin
                    write_reg(lpx_pkg::CFG_MAX_TRIES, lpx_pkg::MAX_TRIES_RST);
                    write_reg(lpx_pkg::CFG_TX_HS, lpx_pkg::TX_HS_RST);
                    write_reg(lpx_pkg::CFG_RX_HS, lpx_pkg::RX_HS_RST);
                end
                default:
                begin
                    write_reg(lpx_pkg::CFG_MAX_TRIES, 8'($urandom_range(1, 40)));
                    write_reg(lpx_pkg::CFG_TX_HS, 8'($urandom_range(0, 255)));
                    write_reg(lpx_pkg::CFG_RX_HS, 8'($urandom_range(0, 255)));
                end
            endcase

            start = useful_items;
            paused = 1'b0;
            while (useful_items - start < ITEMS_PER_SETTING)
            begin
                pick_item(1'b0, c, d, l);
                send_item(c, d, l, 1'b0, '0);
                // one full drain somewhere inside the run
                if (!paused && useful_items - start >= 60)
                begin
                    paused = 1'b1;
                    hold_for_results();
                end
            end
            // finish the exchange in flight before touching registers
            while (lk_state != LS_IDLE)
            begin
                pick_item(1'b1, c, d, l);
                send_item(c, d, l, 1'b0, '0);
            end
        end

        hold_for_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("tb_link_packet_exchange_top: PASS");
        else
            $display("tb_link_packet_exchange_top: FAIL");
        $finish;
    end

endmodule

>>> link_packet_exchange_top.f
rtl/core/lpx_pkg.sv
rtl/core/lpx_ifs.sv
rtl/core/lpx_result_fifo.sv
rtl/core/link_packet_exchange_top.sv
tb/sv/tb_link_packet_exchange_top.sv
